// File: src/kspw_pkg.sv
package kspw_pkg;

  // Operation carried by each input transaction.
  typedef enum logic {
    OP_PITCH = 1'b0,
    OP_LOAD  = 1'b1
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_KEY_FACTOR  = 2'd0,
    CFG_KEY_SHIFT   = 2'd1,
    CFG_FINE_OFFSET = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_t;

  localparam int KEY_COUNT  = 128;
  localparam int KEY_W      = 7;
  localparam int SUM_W      = 21;

  localparam logic signed [7:0]       KEY_CENTER = 8'sd60;
  localparam logic signed [10:0]      KEY_TOP    = 11'sd127;
  localparam logic [KEY_W-1:0]        KEY_MAX    = 7'd127;
  localparam logic [10:0]             FRAC_MUL   = 11'h555;
  localparam logic [17:0]             SEMI_STEP  = 18'(16384 / 12);
  localparam logic [14:0]             DIV3_MUL   = 15'd171;
  localparam int                      DIV3_SHIFT = 9;
  localparam logic [17:0]             REL_CAP    = 18'd32767;
  localparam logic signed [SUM_W-1:0] PITCH_BASE = 21'sh38000;
  localparam logic signed [SUM_W-1:0] PITCH_TOP  = 21'sh3ffff;
  localparam logic [17:0]             PITCH_MAX  = 18'h3ffff;

  // Item leaving the key scaling stages.
  typedef struct packed {
    logic              valid;
    opcode_t           op;
    logic [KEY_W-1:0]  note_key;
    logic [KEY_W-1:0]  sel_key;
    logic              clamped;
    logic [10:0]       fraction;
    logic [KEY_W-1:0]  zone_root;
    logic signed [15:0] pitch_correction;
    logic signed [15:0] table_word;
  } scaled_t;

  // Access to the key table.
  typedef struct packed {
    logic              en;
    logic              wr;
    logic [KEY_W-1:0]  addr;
    logic signed [15:0] wdata;
  } tbl_req_t;

endpackage

// File: src/kspw_scale.sv
module kspw_scale
  import kspw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_opcode,
  input  logic [KEY_W-1:0]        in_note_key,
  input  logic [KEY_W-1:0]        in_zone_root,
  input  logic signed [15:0]      in_pitch_correction,
  input  logic signed [15:0]      in_table_word,
  input  logic signed [15:0]      key_factor,
  input  logic signed [7:0]       key_shift,
  output scaled_t                 scaled,
  input  logic                    scaled_take
);

  logic                v1_r;
  opcode_t             op1_r;
  logic [KEY_W-1:0]    key1_r;
  logic [KEY_W-1:0]    root1_r;
  logic signed [15:0]  corr1_r;
  logic signed [15:0]  word1_r;
  logic signed [23:0]  product1_r;
  logic signed [7:0]   diff;
  logic signed [23:0]  product_nxt;
  logic                en1;
  logic                en2;
  logic signed [9:0]   quot;
  logic signed [10:0]  key_sum;
  logic [15:0]         rem16;
  logic [26:0]         frac_prod;
  scaled_t             s2_nxt;
  scaled_t             s2_r;

  // Stage enables: a stage loads when it is empty or its contents move on.
  assign en2      = !s2_r.valid || scaled_take;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Stage 1: key offset from the center key times the tracking factor.
  assign diff        = signed'({1'b0, in_note_key}) - KEY_CENTER;
  assign product_nxt = diff * key_factor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      op1_r      <= opcode_t'(in_opcode);
      key1_r     <= in_note_key;
      root1_r    <= in_zone_root;
      corr1_r    <= in_pitch_correction;
      word1_r    <= in_table_word;
      product1_r <= product_nxt;
    end
  end

  // Stage 2: floor divide by 16384, add the shift, clamp, form the fraction.
  assign quot      = product1_r[23:14];
  assign key_sum   = 11'(quot) + 11'(KEY_CENTER) + 11'(key_shift);
  assign rem16     = {product1_r[13:0], 2'b00};
  assign frac_prod = FRAC_MUL * rem16;

  always_comb begin
    s2_nxt                  = '0;
    s2_nxt.valid            = v1_r;
    s2_nxt.op               = op1_r;
    s2_nxt.note_key         = key1_r;
    s2_nxt.zone_root        = root1_r;
    s2_nxt.pitch_correction = corr1_r;
    s2_nxt.table_word       = word1_r;
    priority if (key_sum < 11'sd0) begin
      s2_nxt.sel_key  = '0;
      s2_nxt.clamped  = 1'b1;
      s2_nxt.fraction = '0;
    end else if (key_sum > KEY_TOP) begin
      s2_nxt.sel_key  = KEY_MAX;
      s2_nxt.clamped  = 1'b1;
      s2_nxt.fraction = '0;
    end else begin
      s2_nxt.sel_key  = key_sum[KEY_W-1:0];
      s2_nxt.clamped  = 1'b0;
      s2_nxt.fraction = frac_prod[26:16];
    end
  end

  // Stage 2 register: the valid bit resets, the payload loads with its item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (en2) begin
      s2_r.valid <= s2_nxt.valid;
    end
    if (en2 && v1_r) begin
      s2_r.op               <= s2_nxt.op;
      s2_r.note_key         <= s2_nxt.note_key;
      s2_r.sel_key          <= s2_nxt.sel_key;
      s2_r.clamped          <= s2_nxt.clamped;
      s2_r.fraction         <= s2_nxt.fraction;
      s2_r.zone_root        <= s2_nxt.zone_root;
      s2_r.pitch_correction <= s2_nxt.pitch_correction;
      s2_r.table_word       <= s2_nxt.table_word;
    end
  end

  assign scaled = s2_r;

endmodule

// File: src/kspw_table.sv
module kspw_table
  import kspw_pkg::*;
(
  input  logic               clk,
  input  tbl_req_t           req,
  output logic signed [15:0] rdata
);

  logic signed [15:0] mem [KEY_COUNT];
  logic signed [15:0] rdata_r;

  // One access per cycle: a load writes, a pitch transaction reads.
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.wr) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata_r <= mem[req.addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/kspw_pitch.sv
module kspw_pitch
  import kspw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  scaled_t            scaled,
  output logic               scaled_take,
  input  logic signed [15:0] fine_offset,
  input  logic signed [15:0] tbl_rdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [17:0]        out_osc_pitch,
  output logic [KEY_W-1:0]   out_sel_key,
  output logic [10:0]        out_frac_term,
  output logic               out_key_clamped
);

  logic                    en3;
  logic                    en4;
  logic                    v3_r;
  logic                    v4_r;
  logic signed [SUM_W-1:0] base3_r;
  logic [KEY_W-1:0]        sel3_r;
  logic [10:0]             frac3_r;
  logic                    clamp3_r;
  logic signed [7:0]       diff;
  logic [KEY_W-1:0]        mag_key;
  logic [14:0]             third_prod;
  logic [17:0]             mag;
  logic signed [18:0]      rel;
  logic signed [SUM_W-1:0] base_nxt;
  logic signed [SUM_W-1:0] total;
  logic [17:0]             pitch_nxt;
  logic [17:0]             pitch4_r;
  logic [KEY_W-1:0]        sel4_r;
  logic [10:0]             frac4_r;
  logic                    clamp4_r;

  assign en4         = !v4_r || out_ready;
  assign en3         = !v3_r || en4;
  assign scaled_take = en3;

  // Stage 3: relative pitch, (key - root) * 16384 / 12 = 1365 * m + m / 3.
  assign diff       = signed'({1'b0, scaled.sel_key}) - signed'({1'b0, scaled.zone_root});
  assign mag_key    = diff[7] ? 7'(-diff) : diff[KEY_W-1:0];
  assign third_prod = 15'(mag_key) * DIV3_MUL;
  assign mag        = 18'(mag_key) * SEMI_STEP + 18'(third_prod >> DIV3_SHIFT);

  always_comb begin
    priority if (diff[7]) begin
      rel = -signed'({1'b0, mag});
    end else if (mag > REL_CAP) begin
      rel = signed'({1'b0, REL_CAP});
    end else begin
      rel = signed'({1'b0, mag});
    end
  end

  // Every term but the table word is summed here.
  assign base_nxt = PITCH_BASE + SUM_W'(rel) + signed'({10'b0, scaled.fraction})
                  + SUM_W'(scaled.pitch_correction) + SUM_W'(fine_offset);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= scaled.valid && (scaled.op == OP_PITCH);
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && scaled.valid) begin
      base3_r  <= base_nxt;
      sel3_r   <= scaled.sel_key;
      frac3_r  <= scaled.fraction;
      clamp3_r <= scaled.clamped;
    end
  end

  // Stage 4: add the table word and saturate into the output register.
  assign total = base3_r + SUM_W'(tbl_rdata);

  always_comb begin
    priority if (total < 21'sd0) begin
      pitch_nxt = '0;
    end else if (total > PITCH_TOP) begin
      pitch_nxt = PITCH_MAX;
    end else begin
      pitch_nxt = total[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      pitch4_r <= pitch_nxt;
      sel4_r   <= sel3_r;
      frac4_r  <= frac3_r;
      clamp4_r <= clamp3_r;
    end
  end

  assign out_valid       = v4_r;
  assign out_osc_pitch   = pitch4_r;
  assign out_sel_key     = sel4_r;
  assign out_frac_term   = frac4_r;
  assign out_key_clamped = clamp4_r;

endmodule

// File: src/key_scaled_pitch_word_top.sv
// Key-scaled oscillator pitch word.
//
// Input channel (in_valid / in_ready): one transaction per note. With
// in_opcode set to compute, the block returns one result transaction on the
// out_ channel: the pitch word, the clamped selector key, the fraction term
// and the clamp flag. With in_opcode set to load, in_table_word is written
// to the key table at in_note_key and no result is returned.
// Configuration channel (cfg_valid / cfg_ready): cfg_index selects the key
// factor, the key shift or the fine offset; cfg_data carries the value in its
// low bits. cfg_ready is always high. Write only while the block is idle.
// Throughput is one transaction per cycle while the receiver takes results.
// A pitch result passes two scaling stages, the table access stage and the
// output register. When the receiver stalls, each stage holds its item and
// bubbles close up, so in_ready stays high until all four stages are full.
// Reset empties the pipeline and restores the registers to their defaults
// (factor 1.0 in Q14, zero shift, zero offset). The key table is not cleared;
// each entry must be loaded before a note selects it.
module key_scaled_pitch_word_top
  import kspw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [6:0]         in_note_key,
  input  logic [6:0]         in_zone_root,
  input  logic signed [15:0] in_pitch_correction,
  input  logic signed [15:0] in_table_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [17:0]        out_osc_pitch,
  output logic [6:0]         out_sel_key,
  output logic [10:0]        out_frac_term,
  output logic               out_key_clamped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic signed [15:0] key_factor_r;
  logic signed [7:0]  key_shift_r;
  logic signed [15:0] fine_offset_r;
  scaled_t            scaled;
  logic               scaled_take;
  tbl_req_t           tbl_req;
  logic signed [15:0] tbl_rdata;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_factor_r  <= 16'sd16384;
      key_shift_r   <= 8'sd0;
      fine_offset_r <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_KEY_FACTOR:  key_factor_r  <= cfg_data;
        CFG_KEY_SHIFT:   key_shift_r   <= cfg_data[7:0];
        CFG_FINE_OFFSET: fine_offset_r <= cfg_data;
        CFG_UNUSED:      ;
        default:         ;
      endcase
    end
  end

  kspw_scale u_scale (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_note_key         (in_note_key),
    .in_zone_root        (in_zone_root),
    .in_pitch_correction (in_pitch_correction),
    .in_table_word       (in_table_word),
    .key_factor          (key_factor_r),
    .key_shift           (key_shift_r),
    .scaled              (scaled),
    .scaled_take         (scaled_take)
  );

  // Table access happens as an item moves into the third stage.
  always_comb begin
    tbl_req.en    = scaled.valid && scaled_take;
    tbl_req.wr    = (scaled.op == OP_LOAD);
    tbl_req.addr  = tbl_req.wr ? scaled.note_key : scaled.sel_key;
    tbl_req.wdata = scaled.table_word;
  end

  kspw_table u_table (
    .clk   (clk),
    .req   (tbl_req),
    .rdata (tbl_rdata)
  );

  kspw_pitch u_pitch (
    .clk             (clk),
    .rst_n           (rst_n),
    .scaled          (scaled),
    .scaled_take     (scaled_take),
    .fine_offset     (fine_offset_r),
    .tbl_rdata       (tbl_rdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_osc_pitch   (out_osc_pitch),
    .out_sel_key     (out_sel_key),
    .out_frac_term   (out_frac_term),
    .out_key_clamped (out_key_clamped)
  );

endmodule

// File: src/kspw_checker.sv
module kspw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [17:0]        out_osc_pitch,
  input logic [6:0]         out_sel_key,
  input logic [10:0]        out_frac_term,
  input logic               out_key_clamped
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_osc_pitch)
      && $stable(out_sel_key) && $stable(out_frac_term))
    else $error("result changed while stalled");

  // A clamped key carries no fraction.
  a_clamp_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_clamped |-> out_frac_term == 11'd0)
    else $error("fraction on a clamped key");

  // A clamped key sits at one end of the key range.
  a_clamp_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_clamped |-> out_sel_key == 7'd0 || out_sel_key == 7'd127)
    else $error("clamped key inside the range");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind key_scaled_pitch_word_top kspw_checker u_kspw_checker (.*);
